FILE: hdl/nlpd_pkg.sv
// ---------------------------------------------------------------------------
// Nested length-prefix deframer package
// Phase codes, result kinds and the result record shared by the deframer.
// ---------------------------------------------------------------------------
package nlpd_pkg;

  // Deframer phase codes
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_OUTER_HDR = 3'd0;
  localparam logic [PhaseW-1:0] PH_INNER_LO  = 3'd1;
  localparam logic [PhaseW-1:0] PH_INNER_HI  = 3'd2;
  localparam logic [PhaseW-1:0] PH_PAY_FIRST = 3'd3;
  localparam logic [PhaseW-1:0] PH_PAY_REST  = 3'd4;
  localparam logic [PhaseW-1:0] PH_SKIP      = 3'd5;

  // Result kinds
  localparam logic [1:0] EV_PAYLOAD   = 2'd0;
  localparam logic [1:0] EV_EMPTY     = 2'd1;
  localparam logic [1:0] EV_MALFORMED = 2'd2;

  // One result item
  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic       first_of_message;
    logic       last_of_message;
  } nlpd_result_t;

endpackage

FILE: hdl/nested_length_prefix_deframer.sv
// ---------------------------------------------------------------------------
// Nested length-prefix deframer
// Splits a byte stream of length-prefixed frames into inner messages.
// ---------------------------------------------------------------------------
// The block takes one byte of the received stream per clock and gives at most
// one result per byte, registered in a single output register. Frames
// are a 32-bit little-endian length followed by that many bytes; inside, each
// message is a 16-bit little-endian length and its payload. Payload bytes come
// out with tuser kind 0, first-of-message in tuser[2] and last-of-message on
// tlast; a zero-length message gives kind 1, and a malformed frame (a message
// overrunning the frame, or a lone header byte at its end) gives one kind 2
// result, after which the rest of that frame is dropped silently. Throughput
// is one byte per cycle; s_axis_tready drops only while the output register
// holds a result that m_axis_tready does not take.
module nested_length_prefix_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic [2:0] m_axis_tuser,   // [1:0] event_kind, [2] first_of_message
  output logic       m_axis_tlast    // last_of_message
);
  import nlpd_pkg::*;

  logic         step;
  logic         room;
  logic         res_valid;
  nlpd_result_t res;
  nlpd_result_t out_res;

  assign s_axis_tready = room;
  assign step          = s_axis_tvalid && room;

  // frame and message state machine
  nlpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register towards the output stream
  nlpd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .take_i  (m_axis_tready),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tuser = {out_res.first_of_message, out_res.event_kind};
  assign m_axis_tlast = out_res.last_of_message;

endmodule

FILE: hdl/nlpd_core.sv
// ---------------------------------------------------------------------------
// Deframer core
// Frame and message state registers with the next-state and result logic
// for one received byte.
// ---------------------------------------------------------------------------
module nlpd_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,      // byte accepted this cycle
  input  logic [7:0]            rx_byte_i,
  output logic                  res_valid_o,
  output nlpd_pkg::nlpd_result_t res_o
);
  import nlpd_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [1:0]        hdr_idx_q, hdr_idx_d;
  logic [31:0]       len_accum_q, len_accum_d;
  logic [31:0]       frame_left_q, frame_left_d;
  logic [7:0]        inner_lo_q, inner_lo_d;
  logic [15:0]       msg_left_q, msg_left_d;

  logic [31:0] frame_left_dec;
  logic [15:0] msg_left_dec;
  logic [15:0] inner_len;
  logic [31:0] accum_new;

  // Saturating decrements and assembled lengths
  assign frame_left_dec = (frame_left_q != 32'd0) ? frame_left_q - 32'd1 : 32'd0;
  assign msg_left_dec   = (msg_left_q != 16'd0) ? msg_left_q - 16'd1 : 16'd0;
  assign inner_len      = {rx_byte_i, inner_lo_q};
  assign accum_new      = len_accum_q | ({24'd0, rx_byte_i} << {hdr_idx_q, 3'b000});

  // Next state and result for one byte
  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    len_accum_d  = len_accum_q;
    frame_left_d = frame_left_q;
    inner_lo_d   = inner_lo_q;
    msg_left_d   = msg_left_q;
    res_valid_o  = 1'b0;
    res_o        = '0;

    unique case (phase_q)
      PH_INNER_LO: begin
        if (frame_left_q <= 32'd1) begin
          // lone header byte at the frame end
          frame_left_d     = 32'd0;
          phase_d          = PH_OUTER_HDR;
          res_valid_o      = 1'b1;
          res_o.event_kind = EV_MALFORMED;
        end else begin
          frame_left_d = frame_left_q - 32'd1;
          inner_lo_d   = rx_byte_i;
          phase_d      = PH_INNER_HI;
        end
      end

      PH_INNER_HI: begin
        frame_left_d = frame_left_dec;
        res_valid_o  = 1'b1;
        if ({16'd0, inner_len} > frame_left_dec) begin
          // inner length overruns the frame
          phase_d          = (frame_left_dec == 32'd0) ? PH_OUTER_HDR : PH_SKIP;
          res_o.event_kind = EV_MALFORMED;
        end else if (inner_len == 16'd0) begin
          phase_d          = (frame_left_dec == 32'd0) ? PH_OUTER_HDR : PH_INNER_LO;
          res_o.event_kind = EV_EMPTY;
        end else begin
          res_valid_o = 1'b0;
          msg_left_d  = inner_len;
          phase_d     = PH_PAY_FIRST;
        end
      end

      PH_PAY_FIRST, PH_PAY_REST: begin
        frame_left_d           = frame_left_dec;
        msg_left_d             = msg_left_dec;
        res_valid_o            = 1'b1;
        res_o.event_kind       = EV_PAYLOAD;
        res_o.payload_byte     = rx_byte_i;
        res_o.first_of_message = (phase_q == PH_PAY_FIRST);
        res_o.last_of_message  = (msg_left_dec == 16'd0);
        if (msg_left_dec == 16'd0) begin
          phase_d = (frame_left_dec == 32'd0) ? PH_OUTER_HDR : PH_INNER_LO;
        end else begin
          phase_d = PH_PAY_REST;
        end
      end

      PH_SKIP: begin
        frame_left_d = frame_left_dec;
        if (frame_left_dec == 32'd0) begin
          phase_d = PH_OUTER_HDR;
        end
      end

      default: begin
        // outer header, little-endian, one byte lane per byte
        if (hdr_idx_q == 2'd3) begin
          frame_left_d = accum_new;
          len_accum_d  = 32'd0;
          hdr_idx_d    = 2'd0;
          phase_d      = (accum_new == 32'd0) ? PH_OUTER_HDR : PH_INNER_LO;
        end else begin
          len_accum_d = accum_new;
          hdr_idx_d   = hdr_idx_q + 2'd1;
          phase_d     = PH_OUTER_HDR;
        end
      end
    endcase
  end

  // State registers, updated once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_OUTER_HDR;
      hdr_idx_q    <= 2'd0;
      len_accum_q  <= 32'd0;
      frame_left_q <= 32'd0;
      inner_lo_q   <= 8'd0;
      msg_left_q   <= 16'd0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      len_accum_q  <= len_accum_d;
      frame_left_q <= frame_left_d;
      inner_lo_q   <= inner_lo_d;
      msg_left_q   <= msg_left_d;
    end
  end

`ifndef SYNTHESIS
  // skipping only happens while frame bytes remain
  a_skip_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> frame_left_q != 32'd0)
    else $error("skip phase with no frame bytes left");

  // a payload phase always has message bytes outstanding
  a_pay_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY_FIRST || phase_q == PH_PAY_REST) |-> msg_left_q != 16'd0)
    else $error("payload phase with empty message count");

  // a malformed report leaves the frame: skip or next header
  a_malformed_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.event_kind == EV_MALFORMED
    |=> (phase_q == PH_OUTER_HDR || phase_q == PH_SKIP))
    else $error("malformed frame not abandoned");

  // the last payload byte ends the message
  a_last_ends_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.event_kind == EV_PAYLOAD && res_o.last_of_message
    |=> (phase_q == PH_OUTER_HDR || phase_q == PH_INNER_LO))
    else $error("message did not end after its last byte");
`endif

endmodule

FILE: hdl/nlpd_out_reg.sv
// ---------------------------------------------------------------------------
// Deframer result register
// Holds one result for the output stream; refills while being drained.
// ---------------------------------------------------------------------------
module nlpd_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,     // new result this cycle
  input  nlpd_pkg::nlpd_result_t res_i,
  input  logic                  take_i,     // downstream ready
  output logic                  room_o,     // register can take a result
  output logic                  valid_o,
  output nlpd_pkg::nlpd_result_t res_o
);
  import nlpd_pkg::*;

  logic         valid_q, valid_d;
  nlpd_result_t res_q;

  // free when empty or being emptied this cycle
  assign room_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (room_o) begin
      valid_d = load_i;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (room_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
